/* src/wfvc_pkg.sv */
// ----------------------------------------------------------------------------
// wfvc_pkg
// Shared types, mode codes, register indexes and helpers for the
// wall-following velocity controller.
// ----------------------------------------------------------------------------
package wfvc_pkg;

    // Field widths
    localparam int DIST_W = 12;
    localparam int LIN_W  = 12;
    localparam int ANG_W  = 16;
    localparam int CNT_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Surroundings classes
    localparam logic [1:0] MODE_EMPTY = 2'd0;
    localparam logic [1:0] MODE_RIGHT = 2'd1;
    localparam logic [1:0] MODE_LEFT  = 2'd2;
    localparam logic [1:0] MODE_FRONT = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_THRESH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_THRESH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_GAIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_STEP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_STEP    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP_TICKS    = 3'd7;

    // Register reset values
    localparam logic [11:0] OBSTACLE_THRESH_RST = 12'd250;
    localparam logic [11:0] WALL_THRESH_RST     = 12'd150;
    localparam logic [11:0] CRUISE_SPEED_RST    = 12'd200;
    localparam logic [11:0] TURN_SPEED_RST      = 12'd1500;
    localparam logic [7:0]  WALL_GAIN_RST       = 8'd25;
    localparam logic [9:0]  LINEAR_STEP_RST     = 10'd50;
    localparam logic [9:0]  ANGULAR_STEP_RST    = 10'd100;
    localparam logic [7:0]  WARMUP_TICKS_RST    = 8'd11;

    typedef struct packed {
        logic [11:0] obstacle_thresh;
        logic [11:0] wall_thresh;
        logic [11:0] cruise_speed;
        logic [11:0] turn_speed;
        logic [7:0]  wall_gain;
        logic [9:0]  linear_step;
        logic [9:0]  angular_step;
        logic [7:0]  warmup_ticks;
    } cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0] left_front;
        logic [DIST_W-1:0] left_back;
        logic [DIST_W-1:0] front_left;
        logic [DIST_W-1:0] front_right;
        logic [DIST_W-1:0] right_front;
        logic [DIST_W-1:0] right_back;
    } sample_t;

    typedef struct packed {
        logic [LIN_W-1:0]        linear_now;
        logic signed [ANG_W-1:0] angular_now;
        logic                    turn_left;
        logic [CNT_W-1:0]        warmup_count;
    } state_t;

    typedef struct packed {
        logic [LIN_W-1:0]        linear_velocity;
        logic signed [ANG_W-1:0] angular_velocity;
        logic                    command_valid;
        logic [1:0]              mode;
    } result_t;

    // Ramp toward target: move by step while 2*|cur-target| > 3*step,
    // otherwise land on the target. Never overshoots.
    function automatic logic signed [16:0] ramp(
        input logic signed [16:0] cur,
        input logic signed [16:0] target,
        input logic [9:0]         step
    );
        logic signed [17:0] d;
        logic [17:0]        mag;
        logic [18:0]        twice;
        logic [11:0]        thrice;
        logic signed [16:0] step_s;
        logic signed [16:0] r;
        d      = $signed({cur[16], cur}) - $signed({target[16], target});
        mag    = d[17] ? 18'(-d) : 18'(d);
        twice  = {mag, 1'b0};
        thrice = {2'b00, step} + {1'b0, step, 1'b0};
        step_s = $signed({7'd0, step});
        if (twice > {7'd0, thrice})
            r = (d > 18'sd0) ? (cur - step_s) : (cur + step_s);
        else
            r = target;
        return r;
    endfunction

    // Clamp a gain product to 16-bit signed
    function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
        logic signed [15:0] r;
        if (v > 22'sd32767)
            r = 16'sh7fff;
        else if (v < -22'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

/* src/wfvc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// wfvc_cfg_regs
// Configuration register file; writes truncate to each register's width.
// ----------------------------------------------------------------------------
module wfvc_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wfvc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wfvc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output wfvc_pkg::cfg_t                   cfg
);

    wfvc_pkg::cfg_t cfg_reg;
    wfvc_pkg::cfg_t cfg_next;

    // Always able to take a write
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                wfvc_pkg::REG_OBSTACLE_THRESH: cfg_next.obstacle_thresh = cfg_data;
                wfvc_pkg::REG_WALL_THRESH:     cfg_next.wall_thresh     = cfg_data;
                wfvc_pkg::REG_CRUISE_SPEED:    cfg_next.cruise_speed    = cfg_data;
                wfvc_pkg::REG_TURN_SPEED:      cfg_next.turn_speed      = cfg_data;
                wfvc_pkg::REG_WALL_GAIN:       cfg_next.wall_gain       = cfg_data[7:0];
                wfvc_pkg::REG_LINEAR_STEP:     cfg_next.linear_step     = cfg_data[9:0];
                wfvc_pkg::REG_ANGULAR_STEP:    cfg_next.angular_step    = cfg_data[9:0];
                wfvc_pkg::REG_WARMUP_TICKS:    cfg_next.warmup_ticks    = cfg_data[7:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.obstacle_thresh <= wfvc_pkg::OBSTACLE_THRESH_RST;
            cfg_reg.wall_thresh     <= wfvc_pkg::WALL_THRESH_RST;
            cfg_reg.cruise_speed    <= wfvc_pkg::CRUISE_SPEED_RST;
            cfg_reg.turn_speed      <= wfvc_pkg::TURN_SPEED_RST;
            cfg_reg.wall_gain       <= wfvc_pkg::WALL_GAIN_RST;
            cfg_reg.linear_step     <= wfvc_pkg::LINEAR_STEP_RST;
            cfg_reg.angular_step    <= wfvc_pkg::ANGULAR_STEP_RST;
            cfg_reg.warmup_ticks    <= wfvc_pkg::WARMUP_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* src/wfvc_datapath.sv */
// ----------------------------------------------------------------------------
// wfvc_datapath
// Classification and velocity update for one sample set; produces the
// next controller state and the result item.
// ----------------------------------------------------------------------------
module wfvc_datapath
(
    input  wfvc_pkg::cfg_t    cfg,
    input  wfvc_pkg::sample_t smp,
    input  wfvc_pkg::state_t  cur,
    output wfvc_pkg::state_t  nxt,
    output wfvc_pkg::result_t res
);

    logic               front_hit;
    logic               right_wall;
    logic               left_wall;
    logic [12:0]        right_sum;
    logic [12:0]        left_sum;
    logic               turn_left_new;
    logic signed [16:0] turn_pos;
    logic signed [16:0] turn_target;
    logic signed [16:0] ang_cur;
    logic signed [16:0] ang_to_turn;
    logic signed [16:0] ang_to_zero;
    logic signed [16:0] lin_ramped;
    logic signed [12:0] right_diff;
    logic signed [12:0] left_diff;
    logic signed [8:0]  gain_s;
    logic signed [21:0] right_prod;
    logic signed [21:0] left_prod;
    logic               warming;

    // Classification
    assign front_hit  = (smp.front_left < cfg.obstacle_thresh) ||
                        (smp.front_right < cfg.obstacle_thresh);
    assign right_wall = (smp.right_front < cfg.wall_thresh) &&
                        (smp.right_back < cfg.wall_thresh);
    assign left_wall  = (smp.left_front < cfg.wall_thresh) &&
                        (smp.left_back < cfg.wall_thresh);

    // Turn away from the nearer side; tie turns left
    assign right_sum     = {1'b0, smp.right_front} + {1'b0, smp.right_back};
    assign left_sum      = {1'b0, smp.left_front} + {1'b0, smp.left_back};
    assign turn_left_new = !(right_sum > left_sum);

    // Ramps
    assign turn_pos    = $signed({5'd0, cfg.turn_speed});
    assign turn_target = turn_left_new ? turn_pos : -turn_pos;
    assign ang_cur     = $signed({cur.angular_now[15], cur.angular_now});
    assign ang_to_turn = wfvc_pkg::ramp(ang_cur, turn_target, cfg.angular_step);
    assign ang_to_zero = wfvc_pkg::ramp(ang_cur, 17'sd0, cfg.angular_step);
    assign lin_ramped  = wfvc_pkg::ramp($signed({5'd0, cur.linear_now}),
                                        $signed({5'd0, cfg.cruise_speed}),
                                        cfg.linear_step);

    // Wall-following gain terms; right side uses back minus front
    assign gain_s     = $signed({1'b0, cfg.wall_gain});
    assign right_diff = $signed({1'b0, smp.right_back}) - $signed({1'b0, smp.right_front});
    assign left_diff  = $signed({1'b0, smp.left_front}) - $signed({1'b0, smp.left_back});
    assign right_prod = gain_s * right_diff;
    assign left_prod  = gain_s * left_diff;

    assign warming = cur.warmup_count < cfg.warmup_ticks;

    // State update and result
    always_comb
    begin
        nxt = cur;
        res.mode = wfvc_pkg::MODE_EMPTY;
        if (front_hit)
        begin
            res.mode        = wfvc_pkg::MODE_FRONT;
            nxt.turn_left   = turn_left_new;
            nxt.linear_now  = '0;
            nxt.angular_now = ang_to_turn[15:0];
        end
        else if (right_wall)
        begin
            res.mode        = wfvc_pkg::MODE_RIGHT;
            nxt.linear_now  = lin_ramped[11:0];
            nxt.angular_now = wfvc_pkg::sat16(right_prod);
        end
        else if (left_wall)
        begin
            res.mode        = wfvc_pkg::MODE_LEFT;
            nxt.linear_now  = lin_ramped[11:0];
            nxt.angular_now = wfvc_pkg::sat16(left_prod);
        end
        else
        begin
            nxt.linear_now  = lin_ramped[11:0];
            nxt.angular_now = ang_to_zero[15:0];
        end

        if (warming)
            nxt.warmup_count = cur.warmup_count + 8'd1;

        res.linear_velocity  = nxt.linear_now;
        res.angular_velocity = nxt.angular_now;
        res.command_valid    = !warming;
    end

endmodule

/* src/wall_following_velocity_controller.sv */
// ----------------------------------------------------------------------------
// wall_following_velocity_controller
// Top level: input register, velocity datapath, controller state and
// result register.
// ----------------------------------------------------------------------------
// One item per clock while out_stall stays low. An accepted sample set is
// registered in the input register, classified and applied to the velocity
// state from there, and its command lands in the result register, with the
// state update, once the result register is free; out_valid rises with that
// write. The ramped velocities are held in registers that update once per
// item, so each item sees the state its predecessor left. The result register
// lets a new item enter while a finished one waits; in_stall rises only when
// an item sits in the input register and the result register is both full
// and stalled.
module wall_following_velocity_controller
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wfvc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wfvc_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [wfvc_pkg::DIST_W-1:0]      left_front_dist,
    input  logic [wfvc_pkg::DIST_W-1:0]      left_back_dist,
    input  logic [wfvc_pkg::DIST_W-1:0]      front_left_dist,
    input  logic [wfvc_pkg::DIST_W-1:0]      front_right_dist,
    input  logic [wfvc_pkg::DIST_W-1:0]      right_front_dist,
    input  logic [wfvc_pkg::DIST_W-1:0]      right_back_dist,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [wfvc_pkg::LIN_W-1:0]       linear_velocity,
    output logic signed [wfvc_pkg::ANG_W-1:0] angular_velocity,
    output logic                             command_valid,
    output logic [1:0]                       mode
);

    wfvc_pkg::cfg_t    cfg;
    wfvc_pkg::sample_t smp_reg;
    wfvc_pkg::state_t  state_reg;
    wfvc_pkg::state_t  state_next;
    wfvc_pkg::result_t res_reg;
    wfvc_pkg::result_t res_next;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;
    logic              advance;
    logic              load;

    wfvc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wfvc_datapath u_dp
    (
        .cfg (cfg),
        .smp (smp_reg),
        .cur (state_reg),
        .nxt (state_next),
        .res (res_next)
    );

    // Handshake control
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign load     = in_valid && !in_stall;

    assign s1_valid_next  = load ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.linear_now   <= '0;
            state_reg.angular_now  <= '0;
            state_reg.turn_left    <= 1'b1;
            state_reg.warmup_count <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            smp_reg.left_front  <= left_front_dist;
            smp_reg.left_back   <= left_back_dist;
            smp_reg.front_left  <= front_left_dist;
            smp_reg.front_right <= front_right_dist;
            smp_reg.right_front <= right_front_dist;
            smp_reg.right_back  <= right_back_dist;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid        = out_valid_reg;
    assign linear_velocity  = res_reg.linear_velocity;
    assign angular_velocity = res_reg.angular_velocity;
    assign command_valid    = res_reg.command_valid;
    assign mode             = res_reg.mode;

    // Checks
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    a_front_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.mode == wfvc_pkg::MODE_FRONT) |->
        res_reg.linear_velocity == '0)
        else $error("front obstacle result with nonzero linear velocity");

    a_warmup_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.command_valid) |-> state_reg.warmup_count != '0)
        else $error("warm-up result without count advance");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("controller state changed without an item");

endmodule

/* tb/wall_following_velocity_controller_tb.sv */
// ----------------------------------------------------------------------------
// wall_following_velocity_controller_tb
// Self-checking bench for the wall-following velocity controller. A local
// predictor tracks the ramped velocities, turn flag and warm-up count; each
// accepted command is compared field by field against the oldest prediction.
// Directed sets cover the class priority, thresholds, turn ties, saturation
// and zero-step ramps; random runs sweep register settings under random
// idling and back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wall_following_velocity_controller_tb;

    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_PRINTS    = 40;
    localparam int SENSE_W       = wfvc_pkg::DIST_W;

    typedef enum int {
        SCENE_FRONT,
        SCENE_RIGHT,
        SCENE_LEFT,
        SCENE_EMPTY,
        SCENE_NOISE
    } scene_e;

    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [wfvc_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [wfvc_pkg::CFG_DATA_W-1:0]       cfg_data;
    logic                                  in_valid;
    logic                                  in_stall;
    logic [wfvc_pkg::DIST_W-1:0]           left_front_dist;
    logic [wfvc_pkg::DIST_W-1:0]           left_back_dist;
    logic [wfvc_pkg::DIST_W-1:0]           front_left_dist;
    logic [wfvc_pkg::DIST_W-1:0]           front_right_dist;
    logic [wfvc_pkg::DIST_W-1:0]           right_front_dist;
    logic [wfvc_pkg::DIST_W-1:0]           right_back_dist;
    logic                                  out_valid;
    logic                                  out_stall;
    logic [wfvc_pkg::LIN_W-1:0]            linear_velocity;
    logic signed [wfvc_pkg::ANG_W-1:0]     angular_velocity;
    logic                                  command_valid;
    logic [1:0]                            mode;

    // Predictor copy of registers and controller state
    wfvc_pkg::cfg_t cfg_now;
    int             lin_now;
    int             ang_now;
    bit             heading_left;
    int             warm_count;

    wfvc_pkg::result_t pending_cmds[$];
    int      mismatch_count = 0;
    int      idle_pct = 0;
    int      stall_pct = 0;
    int      hold_request = 0;
    int      quiet_cycles = 0;

    wall_following_velocity_controller DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .left_front_dist  (left_front_dist),
        .left_back_dist   (left_back_dist),
        .front_left_dist  (front_left_dist),
        .front_right_dist (front_right_dist),
        .right_front_dist (right_front_dist),
        .right_back_dist  (right_back_dist),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .linear_velocity  (linear_velocity),
        .angular_velocity (angular_velocity),
        .command_valid    (command_valid),
        .mode             (mode)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int ramp_toward(input int cur, input int target, input int step);
        int gap;
        gap = (cur > target) ? cur - target : target - cur;
        if (2 * gap <= 3 * step)
            return target;
        return (cur > target) ? cur - step : cur + step;
    endfunction

    function automatic int clamp_s16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic wfvc_pkg::result_t predict_command(input wfvc_pkg::sample_t s);
        int      lf, lb, fl, fr, rf, rb;
        int      front_lim, side_lim, cruise, turn, gain;
        wfvc_pkg::result_t r;
        lf = s.left_front;
        lb = s.left_back;
        fl = s.front_left;
        fr = s.front_right;
        rf = s.right_front;
        rb = s.right_back;
        front_lim = cfg_now.obstacle_thresh;
        side_lim  = cfg_now.wall_thresh;
        cruise    = cfg_now.cruise_speed;
        turn      = cfg_now.turn_speed;
        gain      = cfg_now.wall_gain;

        // classify with priority front, right, left, empty
        if (fl < front_lim || fr < front_lim)
        begin
            heading_left = !((rf + rb) > (lf + lb));
            r.mode = wfvc_pkg::MODE_FRONT;
            lin_now = 0;
            ang_now = ramp_toward(ang_now, heading_left ? turn : -turn,
                                  cfg_now.angular_step);
        end
        else if (rf < side_lim && rb < side_lim)
        begin
            r.mode = wfvc_pkg::MODE_RIGHT;
            lin_now = ramp_toward(lin_now, cruise, cfg_now.linear_step);
            ang_now = clamp_s16(-(gain * (rf - rb)));
        end
        else if (lf < side_lim && lb < side_lim)
        begin
            r.mode = wfvc_pkg::MODE_LEFT;
            lin_now = ramp_toward(lin_now, cruise, cfg_now.linear_step);
            ang_now = clamp_s16(gain * (lf - lb));
        end
        else
        begin
            r.mode = wfvc_pkg::MODE_EMPTY;
            lin_now = ramp_toward(lin_now, cruise, cfg_now.linear_step);
            ang_now = ramp_toward(ang_now, 0, cfg_now.angular_step);
        end

        // warm-up gate
        if (warm_count < int'(cfg_now.warmup_ticks))
        begin
            warm_count++;
            r.command_valid = 1'b0;
        end
        else
            r.command_valid = 1'b1;

        r.linear_velocity  = lin_now[wfvc_pkg::LIN_W-1:0];
        r.angular_velocity = ang_now[wfvc_pkg::ANG_W-1:0];
        return r;
    endfunction

    function automatic void apply_reg_write(input logic [wfvc_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [wfvc_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            wfvc_pkg::REG_OBSTACLE_THRESH: cfg_now.obstacle_thresh = data[11:0];
            wfvc_pkg::REG_WALL_THRESH:     cfg_now.wall_thresh     = data[11:0];
            wfvc_pkg::REG_CRUISE_SPEED:    cfg_now.cruise_speed    = data[11:0];
            wfvc_pkg::REG_TURN_SPEED:      cfg_now.turn_speed      = data[11:0];
            wfvc_pkg::REG_WALL_GAIN:       cfg_now.wall_gain       = data[7:0];
            wfvc_pkg::REG_LINEAR_STEP:     cfg_now.linear_step     = data[9:0];
            wfvc_pkg::REG_ANGULAR_STEP:    cfg_now.angular_step    = data[9:0];
            wfvc_pkg::REG_WARMUP_TICKS:    cfg_now.warmup_ticks    = data[7:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic wfvc_pkg::sample_t mk(input int lf, input int lb, input int fl,
                                             input int fr, input int rf, input int rb);
        wfvc_pkg::sample_t s;
        s.left_front  = SENSE_W'(lf);
        s.left_back   = SENSE_W'(lb);
        s.front_left  = SENSE_W'(fl);
        s.front_right = SENSE_W'(fr);
        s.right_front = SENSE_W'(rf);
        s.right_back  = SENSE_W'(rb);
        return s;
    endfunction

    // distance strictly below a nonzero limit, often right at the edge; any distance for a zero limit
    function automatic logic [SENSE_W-1:0] dist_under(input int lim);
        if (lim == 0)
            return SENSE_W'($urandom_range(4095, 0));
        if ($urandom_range(4, 0) == 0)
            return SENSE_W'(lim - 1);
        return SENSE_W'($urandom_range(lim - 1, 0));
    endfunction

    // distance at or above a limit, often right at the edge
    function automatic logic [SENSE_W-1:0] dist_over(input int lim);
        if ($urandom_range(4, 0) == 0)
            return SENSE_W'(lim);
        return SENSE_W'($urandom_range(4095, lim));
    endfunction

    function automatic wfvc_pkg::sample_t pick_sample(input scene_e scene);
        wfvc_pkg::sample_t s;
        int      flim, slim;
        flim = cfg_now.obstacle_thresh;
        slim = cfg_now.wall_thresh;
        s = mk($urandom_range(4095, 0), $urandom_range(4095, 0),
               $urandom_range(4095, 0), $urandom_range(4095, 0),
               $urandom_range(4095, 0), $urandom_range(4095, 0));
        if (scene != SCENE_NOISE && scene != SCENE_FRONT)
        begin
            s.front_left  = dist_over(flim);
            s.front_right = dist_over(flim);
        end
        case (scene)
            SCENE_FRONT:
                if ($urandom_range(1, 0))
                    s.front_left = dist_under(flim);
                else
                    s.front_right = dist_under(flim);
            SCENE_RIGHT:
            begin
                s.right_front = dist_under(slim);
                s.right_back  = dist_under(slim);
            end
            SCENE_LEFT:
            begin
                if ($urandom_range(1, 0))
                    s.right_front = dist_over(slim);
                else
                    s.right_back = dist_over(slim);
                s.left_front = dist_under(slim);
                s.left_back  = dist_under(slim);
            end
            SCENE_EMPTY:
            begin
                if ($urandom_range(1, 0))
                    s.right_front = dist_over(slim);
                else
                    s.right_back = dist_over(slim);
                if ($urandom_range(1, 0))
                    s.left_front = dist_over(slim);
                else
                    s.left_back = dist_over(slim);
            end
            default: ;
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------
    task automatic send_sample(input wfvc_pkg::sample_t s);
        int gap;
        if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(2, 1);
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        left_front_dist  <= s.left_front;
        left_back_dist   <= s.left_back;
        front_left_dist  <= s.front_left;
        front_right_dist <= s.front_right;
        right_front_dist <= s.right_front;
        right_back_dist  <= s.right_back;
        do @(posedge clk); while (in_stall);
        pending_cmds.push_back(predict_command(s));
    endtask

    // stop offering items and wait out every pending command
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [wfvc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wfvc_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_reg_write(idx, data);
    endtask

    // write every register; narrow ones get junk in the unused upper bits
    task automatic load_settings(input wfvc_pkg::cfg_t c);
        write_reg(wfvc_pkg::REG_OBSTACLE_THRESH, c.obstacle_thresh);
        write_reg(wfvc_pkg::REG_WALL_THRESH, c.wall_thresh);
        write_reg(wfvc_pkg::REG_CRUISE_SPEED, c.cruise_speed);
        write_reg(wfvc_pkg::REG_TURN_SPEED, c.turn_speed);
        write_reg(wfvc_pkg::REG_WALL_GAIN, {4'($urandom), c.wall_gain});
        write_reg(wfvc_pkg::REG_LINEAR_STEP, {2'($urandom), c.linear_step});
        write_reg(wfvc_pkg::REG_ANGULAR_STEP, {2'($urandom), c.angular_step});
        write_reg(wfvc_pkg::REG_WARMUP_TICKS, {4'($urandom), c.warmup_ticks});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_scenes(input int count);
        scene_e scene;
        int     run_len;
        int     r;
        int     sent;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(99, 0);
            scene = (r < 10) ? SCENE_NOISE : scene_e'(r % 4);
            run_len = $urandom_range(10, 1);
            repeat (run_len)
            begin
                send_sample(pick_sample(scene));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset settings: warm-up, class priority, thresholds and turn choice
    task automatic test_modes_at_reset();
        idle_pct  = 10;
        stall_pct = 10;
        send_sample(mk(0, 0, 0, 0, 0, 0));                   // front, tie turns left
        send_sample(mk(4095, 4095, 4095, 4095, 4095, 4095)); // empty
        send_sample(mk(500, 500, 100, 4095, 600, 600));      // front, turns right
        send_sample(mk(500, 500, 4095, 249, 400, 400));      // front via right sensor
        send_sample(mk(4095, 4095, 250, 250, 4095, 4095));   // at front limit: empty
        send_sample(mk(4095, 4095, 4095, 4095, 0, 149));     // right wall
        send_sample(mk(0, 149, 4095, 4095, 149, 0));         // right beats left
        send_sample(mk(149, 0, 4095, 4095, 150, 0));         // left wall
        send_sample(mk(0, 150, 4095, 4095, 4095, 4095));     // one side at limit
        send_sample(mk(149, 149, 4095, 4095, 4095, 4095));   // left, no error
        // empty scene; linear is already at cruise and holds there
        repeat (6) send_sample(mk(1000, 1000, 1000, 1000, 1000, 1000));
        // angular ramps toward the turn rate
        repeat (4) send_sample(mk(300, 300, 10, 10, 200, 200));
        settle_block();
    endtask

    // Extreme register values: saturation, full-scale turn, zero steps
    task automatic test_register_extremes();
        wfvc_pkg::cfg_t c;
        c = cfg_now;
        c.obstacle_thresh = 12'd0;
        c.wall_thresh     = 12'd4095;
        c.cruise_speed    = 12'd4095;
        c.turn_speed      = 12'd4095;
        c.wall_gain       = 8'd255;
        c.linear_step     = 10'd1023;
        c.angular_step    = 10'd1023;
        c.warmup_ticks    = 8'd0;
        load_settings(c);
        send_sample(mk(4095, 4095, 0, 0, 0, 4094));      // right, positive clamp
        send_sample(mk(4095, 4095, 0, 0, 4094, 0));      // right, negative clamp
        send_sample(mk(4094, 0, 0, 0, 4095, 4095));     // left, positive clamp
        send_sample(mk(0, 4094, 0, 0, 4095, 4095));     // left, negative clamp
        send_sample(mk(4094, 4094, 0, 0, 4095, 4095));  // left, zero error
        send_sample(mk(4095, 4095, 0, 0, 4095, 4095));  // empty
        settle_block();

        c.obstacle_thresh = 12'd4095;
        load_settings(c);
        repeat (5) send_sample(mk(0, 0, 4094, 4095, 4095, 4095)); // hard right turn
        settle_block();

        // zero steps: ramps hold unless already on target
        c.obstacle_thresh = 12'd100;
        c.wall_thresh     = 12'd100;
        c.linear_step     = 10'd0;
        c.angular_step    = 10'd0;
        load_settings(c);
        repeat (3) send_sample(mk(4095, 4095, 4095, 4095, 4095, 4095));
        send_sample(mk(0, 0, 0, 0, 0, 0));
        repeat (2) send_sample(mk(4095, 4095, 4095, 4095, 4095, 4095));
        settle_block();
    endtask

    // Random traffic across several register settings
    task automatic test_random_traffic();
        wfvc_pkg::cfg_t c;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    c.obstacle_thresh = 12'($urandom_range(4095, 0));
                    c.wall_thresh     = 12'($urandom_range(4095, 0));
                    c.cruise_speed    = 12'($urandom_range(4095, 0));
                    c.turn_speed      = 12'($urandom_range(4095, 0));
                    c.wall_gain       = 8'($urandom_range(255, 0));
                    c.linear_step     = 10'($urandom_range(1023, 0));
                    c.angular_step    = 10'($urandom_range(1023, 0));
                    c.warmup_ticks    = 8'd255;
                end
                1:
                begin
                    c.obstacle_thresh = 12'd4095;
                    c.wall_thresh     = 12'd4095;
                    c.cruise_speed    = 12'd4095;
                    c.turn_speed      = 12'd4095;
                    c.wall_gain       = 8'd255;
                    c.linear_step     = 10'd1023;
                    c.angular_step    = 10'd1023;
                    c.warmup_ticks    = 8'd255;
                end
                2:
                begin
                    c = '0;
                end
                3:
                begin
                    c.obstacle_thresh = 12'($urandom_range(800, 100));
                    c.wall_thresh     = 12'($urandom_range(800, 100));
                    c.cruise_speed    = 12'($urandom_range(4095, 1000));
                    c.turn_speed      = 12'($urandom_range(4095, 1000));
                    c.wall_gain       = 8'($urandom_range(255, 0));
                    c.linear_step     = 10'($urandom_range(3, 1));
                    c.angular_step    = 10'($urandom_range(3, 1));
                    c.warmup_ticks    = (warm_count + 20 > 255) ? 8'd255
                                                                : 8'(warm_count + 20);
                end
                default:
                begin
                    c.obstacle_thresh = 12'($urandom_range(1500, 0));
                    c.wall_thresh     = 12'($urandom_range(1500, 0));
                    c.cruise_speed    = 12'($urandom_range(4095, 0));
                    c.turn_speed      = 12'($urandom_range(4095, 0));
                    c.wall_gain       = 8'($urandom_range(255, 0));
                    c.linear_step     = 10'($urandom_range(400, 0));
                    c.angular_step    = 10'($urandom_range(400, 0));
                    c.warmup_ticks    = 8'($urandom_range(255, 0));
                end
            endcase
            // one phase runs flat out with no idling on either side
            idle_pct  = (phase == 4) ? 0 : 10;
            stall_pct = (phase == 4) ? 0 : 10;
            load_settings(c);
            send_scenes(90);
            settle_block();
        end
    endtask

    // Receiver holds off long enough for the block to fill and stall input
    task automatic test_backpressure();
        idle_pct     = 0;
        stall_pct    = 10;
        hold_request = 50;
        send_scenes(40);
        // sender pauses until every command is back
        settle_block();
        idle_pct = 10;
        send_scenes(20);
        settle_block();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls plus requested long holds
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (!rst_n)
                out_stall <= 1'b0;
            else if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input int got, input int want);
        // keep the log short when everything goes wrong
        if (mismatch_count < MAX_PRINTS)
            $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : command_check
        wfvc_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_cmds.size() == 0)
                report_mismatch("unexpected command", 1, 0);
            else
            begin
                want = pending_cmds.pop_front();
                if (linear_velocity !== want.linear_velocity)
                    report_mismatch("linear_velocity", linear_velocity,
                                    want.linear_velocity);
                if (angular_velocity !== want.angular_velocity)
                    report_mismatch("angular_velocity", angular_velocity,
                                    want.angular_velocity);
                if (command_valid !== want.command_valid)
                    report_mismatch("command_valid", command_valid,
                                    want.command_valid);
                if (mode !== want.mode)
                    report_mismatch("mode", mode, want.mode);
            end
        end
    end

    // Watchdog: give up when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        left_front_dist  = '0;
        left_back_dist   = '0;
        front_left_dist  = '0;
        front_right_dist = '0;
        right_front_dist = '0;
        right_back_dist  = '0;

        cfg_now.obstacle_thresh = wfvc_pkg::OBSTACLE_THRESH_RST;
        cfg_now.wall_thresh     = wfvc_pkg::WALL_THRESH_RST;
        cfg_now.cruise_speed    = wfvc_pkg::CRUISE_SPEED_RST;
        cfg_now.turn_speed      = wfvc_pkg::TURN_SPEED_RST;
        cfg_now.wall_gain       = wfvc_pkg::WALL_GAIN_RST;
        cfg_now.linear_step     = wfvc_pkg::LINEAR_STEP_RST;
        cfg_now.angular_step    = wfvc_pkg::ANGULAR_STEP_RST;
        cfg_now.warmup_ticks    = wfvc_pkg::WARMUP_TICKS_RST;
        lin_now      = 0;
        ang_now      = 0;
        heading_left = 1'b1;
        warm_count   = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_modes_at_reset();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();

        settle_block();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
